// File: rtl/core/bitmap_page_frame_allocator_defines.svh
// Assertion macros shared by the allocator's checker.
// Depends on nothing; the using module must have clk and rst in scope.
`ifndef BITMAP_PAGE_FRAME_ALLOCATOR_DEFINES_SVH
`define BITMAP_PAGE_FRAME_ALLOCATOR_DEFINES_SVH

// Property checked at every rising edge outside reset.
`define BPFA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked at every rising edge, reset included.
`define BPFA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/bpfa_pkg.sv
// Shared types and constants of the bitmap page frame allocator.
// Depends on nothing; the files that use it take names from here by scope.
`timescale 1ns / 1ps

package bpfa_pkg;

  // Field widths of the stream payloads.
  localparam int FRAME_W = 20;
  localparam int TDATA_W = 24;

  // Operation codes carried in the input tuser.
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Result status carried in the output tuser.
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_FREE = 2'd1,
    ST_BEYOND  = 2'd2
  } status_t;

  // Command kinds decided by the front end.
  typedef enum logic [1:0] {
    CMD_ALLOC  = 2'd0,
    CMD_FREE   = 2'd1,
    CMD_REJECT = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [FRAME_W-1:0] frame;
  } cmd_t;

  // Command queue between front and back end.
  localparam int QUEUE_DEPTH = 2;

  // Queue view seen by the back end.
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } queue_head_t;

endpackage

// File: rtl/core/bpfa_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
`timescale 1ns / 1ps

module bpfa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/bpfa_queue.sv
// Short command queue that decouples the front end from the back end.
// Depends on bpfa_pkg for the command type and depth.
`timescale 1ns / 1ps

module bpfa_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  bpfa_pkg::cmd_t        push_cmd,
  output logic                  full,
  input  logic                  pop,
  output bpfa_pkg::queue_head_t head
);

  localparam int PTR_W = (bpfa_pkg::QUEUE_DEPTH > 1) ? $clog2(bpfa_pkg::QUEUE_DEPTH) : 1;

  bpfa_pkg::cmd_t entry [bpfa_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;

  assign full       = (count == (PTR_W + 1)'(bpfa_pkg::QUEUE_DEPTH));
  assign head.valid = (count != '0);
  assign head.cmd   = entry[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(bpfa_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(bpfa_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + (PTR_W + 1)'(1);
      end else if (pop && !push) begin
        count <= count - (PTR_W + 1)'(1);
      end
    end
  end

endmodule

// File: rtl/core/bpfa_front.sv
// Front end: takes input transfers and sorts them into allocate, free and
// out-of-range commands for the queue. Depends on bpfa_pkg.
`timescale 1ns / 1ps

module bpfa_front #(
  parameter int NUM_FRAMES = 65536
) (
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [bpfa_pkg::TDATA_W-1:0] s_tdata,
  input  logic [0:0]                   s_tuser,
  input  logic                         q_full,
  input  logic                         back_ready,
  output logic                         push,
  output bpfa_pkg::cmd_t               push_cmd
);

  localparam int FW = bpfa_pkg::FRAME_W;

  logic [FW-1:0] frame;
  logic          beyond;

  assign frame  = s_tdata[FW-1:0];
  assign beyond = ({1'b0, frame} >= (FW + 1)'(NUM_FRAMES));

  // Accept only once the map is initialised and the queue has room.
  assign s_tready = !q_full && back_ready;
  assign push     = s_tvalid && s_tready;

  // Classify the transfer.
  always_comb begin
    push_cmd.frame = frame;
    if (s_tuser[0] == bpfa_pkg::OP_ALLOC) begin
      push_cmd.kind = bpfa_pkg::CMD_ALLOC;
    end else if (beyond) begin
      push_cmd.kind = bpfa_pkg::CMD_REJECT;
    end else begin
      push_cmd.kind = bpfa_pkg::CMD_FREE;
    end
  end

endmodule

// File: rtl/core/bpfa_back.sv
// Back end: owns the bitmap RAM, runs the first-fit scan and the frees,
// and holds the result register. Depends on bpfa_pkg and bpfa_ram.
`timescale 1ns / 1ps

module bpfa_back #(
  parameter int NUM_FRAMES = 65536,
  parameter int WORD_BITS  = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  bpfa_pkg::queue_head_t        head,
  output logic                         pop,
  output logic                         ready,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [bpfa_pkg::TDATA_W-1:0] m_tdata,
  output logic [1:0]                   m_tuser
);

  localparam int MAP_WORDS = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int ADDR_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int FW        = bpfa_pkg::FRAME_W;
  localparam logic [ADDR_W-1:0] LAST_WORD = ADDR_W'(MAP_WORDS - 1);
  // Reciprocal of WORD_BITS, exact for every frame number of FW bits.
  localparam int RECIP_SH  = FW + BIT_W;
  localparam int PROD_W    = RECIP_SH + FW;
  localparam logic [FW:0] RECIP_M =
    (FW + 1)'(((64'd1 << RECIP_SH) + 64'(WORD_BITS) - 64'd1) / 64'(WORD_BITS));

  typedef enum logic [7:0] {
    S_INIT   = 8'b0000_0001,
    S_IDLE   = 8'b0000_0010,
    S_SCAN   = 8'b0000_0100,
    S_PICK   = 8'b0000_1000,
    S_SET    = 8'b0001_0000,
    S_DIV    = 8'b0010_0000,
    S_FREAD  = 8'b0100_0000,
    S_FWRITE = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;

  logic [ADDR_W-1:0]    init_cnt;
  logic [ADDR_W-1:0]    chk;
  logic [WORD_BITS-1:0] word_reg;
  logic [BIT_W-1:0]     bit_idx;
  logic [FW-1:0]        div_n;
  logic [FW-1:0]        div_q;
  logic [BIT_W-1:0]     div_rem;
  logic                 out_valid;
  logic [FW-1:0]        out_frame;
  bpfa_pkg::status_t    out_status;

  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic                 ram_re;
  logic [ADDR_W-1:0]    ram_raddr;
  logic [WORD_BITS-1:0] ram_rdata;

  logic                 word_full;
  logic [BIT_W-1:0]     zero_idx;
  logic [PROD_W-1:0]    div_prod;
  logic [FW-1:0]        rem_full;
  logic [ADDR_W-1:0]    free_word;

  bpfa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAP_WORDS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign ready     = (state != S_INIT);
  assign pop       = (state == S_IDLE) && head.valid && !out_valid;
  assign word_full = &ram_rdata;
  assign free_word = div_q[ADDR_W-1:0];

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(bpfa_pkg::TDATA_W - FW){1'b0}}, out_frame};
  assign m_tuser  = out_status;

  // Lowest clear bit of the captured word.
  always_comb begin
    zero_idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!word_reg[i]) begin
        zero_idx = BIT_W'(i);
      end
    end
  end

  // Word index by reciprocal multiplication, then the bit index as what is left.
  assign div_prod = PROD_W'(div_n) * PROD_W'(RECIP_M);
  assign rem_full = div_n - div_q * FW'(WORD_BITS);

  // RAM port control.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = init_cnt;
    ram_wdata = '1;
    ram_re    = 1'b0;
    ram_raddr = '0;
    case (state)
      S_INIT: begin
        ram_we = 1'b1;
      end
      S_IDLE: begin
        ram_re = pop && (head.cmd.kind == bpfa_pkg::CMD_ALLOC);
      end
      S_SCAN: begin
        ram_re    = (chk != LAST_WORD);
        ram_raddr = chk + ADDR_W'(1);
      end
      S_SET: begin
        ram_we    = 1'b1;
        ram_waddr = chk;
        ram_wdata = word_reg | (WORD_BITS'(1) << bit_idx);
      end
      S_FREAD: begin
        ram_re    = 1'b1;
        ram_raddr = free_word;
      end
      S_FWRITE: begin
        ram_we    = 1'b1;
        ram_waddr = free_word;
        ram_wdata = ram_rdata & ~(WORD_BITS'(1) << div_rem);
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      S_INIT: begin
        if (init_cnt == LAST_WORD) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (pop) begin
          case (head.cmd.kind)
            bpfa_pkg::CMD_ALLOC: state_next = S_SCAN;
            bpfa_pkg::CMD_FREE:  state_next = S_DIV;
            default:             state_next = S_IDLE;
          endcase
        end
      end
      S_SCAN: begin
        if (!word_full) begin
          state_next = S_PICK;
        end else if (chk == LAST_WORD) begin
          state_next = S_IDLE;
        end
      end
      S_PICK:   state_next = S_SET;
      S_SET:    state_next = S_IDLE;
      S_DIV:    state_next = S_FREAD;
      S_FREAD:  state_next = S_FWRITE;
      S_FWRITE: state_next = S_IDLE;
      default:  state_next = S_INIT;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      init_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_INIT) begin
        init_cnt <= init_cnt + ADDR_W'(1);
      end
      if (out_valid && m_tready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (pop && head.cmd.kind == bpfa_pkg::CMD_REJECT) out_valid <= 1'b1;
        end
        S_SCAN: begin
          if (word_full && chk == LAST_WORD) out_valid <= 1'b1;
        end
        S_SET:    out_valid <= 1'b1;
        S_FWRITE: out_valid <= 1'b1;
        default: begin
        end
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        chk     <= '0;
        div_n   <= head.cmd.frame;
        div_q   <= '0;
        div_rem <= '0;
        if (pop && head.cmd.kind == bpfa_pkg::CMD_REJECT) begin
          out_frame  <= '0;
          out_status <= bpfa_pkg::ST_BEYOND;
        end
      end
      S_SCAN: begin
        if (!word_full) begin
          word_reg <= ram_rdata;
        end else if (chk == LAST_WORD) begin
          out_frame  <= '0;
          out_status <= bpfa_pkg::ST_NO_FREE;
        end else begin
          chk <= chk + ADDR_W'(1);
        end
      end
      S_PICK: begin
        bit_idx <= zero_idx;
      end
      S_SET: begin
        out_frame  <= FW'(chk) * FW'(WORD_BITS) + FW'(bit_idx);
        out_status <= bpfa_pkg::ST_OK;
      end
      S_DIV: begin
        div_q <= div_prod[RECIP_SH +: FW];
      end
      S_FREAD: begin
        div_rem <= rem_full[BIT_W-1:0];
      end
      S_FWRITE: begin
        out_frame  <= '0;
        out_status <= bpfa_pkg::ST_OK;
      end
      default: begin
      end
    endcase
  end

endmodule

// File: rtl/core/bitmap_page_frame_allocator.sv
// First-fit bitmap page frame allocator: front end, command queue, back end.
// After reset the map is filled with ones, one word a cycle, and no transfer is
// taken until that is done. Allocate: words are scanned in order, one RAM read a
// cycle, until one has a clear bit, whose lowest clear bit is picked and set; with
// no free frame the status is no free. Free: word index by reciprocal multiply,
// RAM read, RAM write; a rejected free gets its result straight from idle. Items
// are worked one at a time; a two-deep queue buffers input.
`timescale 1ns / 1ps

module bitmap_page_frame_allocator #(
  parameter int NUM_FRAMES = 65536,
  parameter int WORD_BITS  = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // [19:0] frame_number, [23:20] zero
  input  logic [bpfa_pkg::TDATA_W-1:0] s_tdata,
  // [0] operation
  input  logic [0:0]                   s_tuser,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // [19:0] granted_frame, [23:20] zero
  output logic [bpfa_pkg::TDATA_W-1:0] m_tdata,
  // [1:0] status
  output logic [1:0]                   m_tuser
);

  logic                  q_full;
  logic                  q_push;
  bpfa_pkg::cmd_t        q_cmd;
  logic                  q_pop;
  bpfa_pkg::queue_head_t q_head;
  logic                  back_ready;

  // Classify incoming transfers.
  bpfa_front #(
    .NUM_FRAMES (NUM_FRAMES)
  ) u_front (
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .q_full     (q_full),
    .back_ready (back_ready),
    .push       (q_push),
    .push_cmd   (q_cmd)
  );

  // Command queue.
  bpfa_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head)
  );

  // Bitmap work and result register.
  bpfa_back #(
    .NUM_FRAMES (NUM_FRAMES),
    .WORD_BITS  (WORD_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (q_head),
    .pop      (q_pop),
    .ready    (back_ready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

// File: rtl/core/bpfa_checker.sv
// Port-level checks of the allocator, bound to the top level.
// Depends on bpfa_pkg and bitmap_page_frame_allocator_defines.svh.
`timescale 1ns / 1ps
`include "bitmap_page_frame_allocator_defines.svh"

module bpfa_checker #(
  parameter int NUM_FRAMES = 65536
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         s_tvalid,
  input logic                         s_tready,
  input logic [bpfa_pkg::TDATA_W-1:0] s_tdata,
  input logic [0:0]                   s_tuser,
  input logic                         m_tvalid,
  input logic                         m_tready,
  input logic [bpfa_pkg::TDATA_W-1:0] m_tdata,
  input logic [1:0]                   m_tuser
);

  // A stalled result transfer keeps its contents.
  `BPFA_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

  // Failed requests carry a zero frame.
  `BPFA_ASSERT(a_fail_zero, m_tvalid && m_tuser != bpfa_pkg::ST_OK |-> m_tdata == '0, "non-zero frame on failure")

  // A granted frame lies inside the table.
  `BPFA_ASSERT(a_grant_range, m_tvalid && m_tuser == bpfa_pkg::ST_OK |-> m_tdata < NUM_FRAMES, "granted frame beyond table")

  // Reset empties the result register and holds off input during map fill.
  `BPFA_ASSERT_ALWAYS(a_reset_quiet, rst |=> !m_tvalid && !s_tready, "activity right after reset")

endmodule

bind bitmap_page_frame_allocator bpfa_checker #(
  .NUM_FRAMES (NUM_FRAMES)
) u_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

// File: bench/tb.sv
// Self-checking bench for the first-fit bitmap page frame allocator.
// Depends on bpfa_pkg and bitmap_page_frame_allocator; it predicts every result
// from its own copy of the frame map and checks each output transfer against it.
`timescale 1ns / 1ps

module tb;

  localparam int NUM_FRAMES = 65536;
  localparam int WORD_BITS  = 32;
  localparam int MAP_WORDS  = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int FRAME_W    = bpfa_pkg::FRAME_W;
  localparam int TDATA_W    = bpfa_pkg::TDATA_W;
  // A full-map allocate scan plus margin; used for the quiet time at the end.
  localparam int SETTLE_CYCLES = 2100;

  // One predicted result: the frame handed out and the status.
  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    bpfa_pkg::status_t  status;
  } grant_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [TDATA_W-1:0] s_tdata = '0;
  logic [0:0]         s_tuser = '0;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [TDATA_W-1:0] m_tdata;
  logic [1:0]         m_tuser;

  // Predicted frame map, one bit per frame, 1 meaning used.
  logic [WORD_BITS-1:0] frame_used [MAP_WORDS];
  // Results still owed by the block, oldest first.
  grant_t               expected_grants [$];
  // Frames granted so far, used to free frames that are really in use.
  logic [FRAME_W-1:0]   granted_frames [$];
  int                   mismatch_count = 0;
  bit                   feed_gaps = 1'b1;
  bit                   sink_stalls = 1'b1;

  bitmap_page_frame_allocator #(
    .NUM_FRAMES(NUM_FRAMES),
    .WORD_BITS (WORD_BITS)
  ) uut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  always #4 clk = ~clk;

  // Applies one request to the predicted map and returns the result it causes.
  function automatic grant_t predict_frame_op(input logic op, input logic [FRAME_W-1:0] frame);
    grant_t res;
    bit     found;
    res.frame  = '0;
    res.status = bpfa_pkg::ST_OK;
    found      = 1'b0;
    if (op == bpfa_pkg::OP_ALLOC) begin
      // First fit: skip full words, then take the lowest clear bit.
      for (int w = 0; w < MAP_WORDS; w++) begin
        if (!found && frame_used[w] != '1) begin
          for (int b = 0; b < WORD_BITS; b++) begin
            if (!found && w * WORD_BITS + b < NUM_FRAMES && !frame_used[w][b]) begin
              frame_used[w][b] = 1'b1;
              res.frame        = FRAME_W'(w * WORD_BITS + b);
              found            = 1'b1;
            end
          end
        end
      end
      if (!found) res.status = bpfa_pkg::ST_NO_FREE;
    end else if (frame >= NUM_FRAMES) begin
      res.status = bpfa_pkg::ST_BEYOND;
    end else begin
      frame_used[frame / WORD_BITS][frame % WORD_BITS] = 1'b0;
    end
    return res;
  endfunction

  // Sends one request, starting and ending at a falling edge, and records the
  // result it must produce once the transfer has taken place.
  task automatic send_request(input logic op, input logic [FRAME_W-1:0] frame);
    grant_t res;
    if (feed_gaps && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(TDATA_W - FRAME_W){1'b0}}, frame};
    s_tuser  <= op;
    do @(posedge clk); while (!s_tready);
    res = predict_frame_op(op, frame);
    expected_grants.push_back(res);
    if (op == bpfa_pkg::OP_ALLOC && res.status == bpfa_pkg::ST_OK) begin
      granted_frames.push_back(res.frame);
    end
    @(negedge clk);
  endtask

  // Output side: ready held high, with random stalls while they are enabled.
  always begin
    @(negedge clk);
    if (sink_stalls && $urandom_range(0, 4) == 0) begin
      m_tready <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    m_tready <= 1'b1;
  end

  // Each output transfer is compared with the oldest outstanding prediction.
  always @(posedge clk) begin
    grant_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_grants.size() == 0) begin
        $error("unexpected result: granted_frame %0d status %0d",
               m_tdata[FRAME_W-1:0], m_tuser);
        mismatch_count++;
      end else begin
        want = expected_grants.pop_front();
        if (m_tdata[FRAME_W-1:0] !== want.frame) begin
          $error("granted_frame: expected %0d, got %0d", want.frame, m_tdata[FRAME_W-1:0]);
          mismatch_count++;
        end
        if (m_tuser !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_tuser);
          mismatch_count++;
        end
      end
    end
  end

  // Every frame is used after reset, so allocation must fail.
  task automatic test_empty_after_reset();
    send_request(bpfa_pkg::OP_ALLOC, '0);
    send_request(bpfa_pkg::OP_ALLOC, '1);
  endtask

  // Frees at or above the table size are rejected and leave the map alone.
  task automatic test_beyond_table();
    send_request(bpfa_pkg::OP_FREE, FRAME_W'(NUM_FRAMES));
    send_request(bpfa_pkg::OP_FREE, '1);
    send_request(bpfa_pkg::OP_FREE, 20'hAAAAA);
    send_request(bpfa_pkg::OP_FREE, 20'h55555);
    send_request(bpfa_pkg::OP_ALLOC, 20'h12345);
  endtask

  // Frees at word edges, a repeated free, then first-fit reuse up to exhaustion.
  task automatic test_free_and_reuse();
    send_request(bpfa_pkg::OP_FREE, '0);
    send_request(bpfa_pkg::OP_FREE, '0);
    send_request(bpfa_pkg::OP_FREE, FRAME_W'(WORD_BITS - 1));
    send_request(bpfa_pkg::OP_FREE, FRAME_W'(WORD_BITS));
    send_request(bpfa_pkg::OP_FREE, FRAME_W'(NUM_FRAMES - 1));
    repeat (5) send_request(bpfa_pkg::OP_ALLOC, FRAME_W'($urandom()));
    send_request(bpfa_pkg::OP_FREE, FRAME_W'(NUM_FRAMES - 1));
    send_request(bpfa_pkg::OP_ALLOC, '0);
    send_request(bpfa_pkg::OP_FREE, FRAME_W'(WORD_BITS));
  endtask

  // Random mix of allocations and frees, biased towards low frames so that
  // most allocations find a frame after a short scan.
  task automatic random_requests(input int count);
    int                 pick;
    int                 idx;
    logic [FRAME_W-1:0] frame;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        send_request(bpfa_pkg::OP_ALLOC, FRAME_W'($urandom()));
      end else begin
        if (pick < 80 && pick >= 65 && granted_frames.size() != 0) begin
          idx   = $urandom_range(0, granted_frames.size() - 1);
          frame = granted_frames[idx];
          granted_frames.delete(idx);
        end else if (pick < 80) begin
          frame = FRAME_W'($urandom_range(0, 255));
        end else if (pick < 90) begin
          frame = FRAME_W'($urandom_range(0, NUM_FRAMES - 1));
        end else begin
          frame = FRAME_W'($urandom_range(NUM_FRAMES, (1 << FRAME_W) - 1));
        end
        send_request(bpfa_pkg::OP_FREE, frame);
      end
    end
  endtask

  task automatic test_random_mix();
    feed_gaps   = 1'b1;
    sink_stalls = 1'b1;
    random_requests(200);
  endtask

  // Back-to-back transfers on both sides for the last part of the run.
  task automatic test_steady_stream();
    feed_gaps   = 1'b0;
    sink_stalls = 1'b0;
    random_requests(70);
  endtask

  initial begin
    foreach (frame_used[i]) frame_used[i] = '1;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    test_empty_after_reset();
    test_beyond_table();
    test_free_and_reuse();
    test_random_mix();
    test_steady_stream();
    s_tvalid <= 1'b0;
    while (expected_grants.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  // Guard against a hang: far beyond the slowest correct run.
  initial begin
    #(30_000_000);
    $display("tb: done, errors");
    $finish;
  end

endmodule
